FILE: rtl/gld_pkg.sv
// Shared types, constants and the checked subtraction for the lagged difference block.
package gld_pkg;

	localparam int MAX_LAG_DEF   = 64;
	localparam int MAX_ORDER_DEF = 4;
	localparam int DATA_W        = 32;
	localparam int LAG_W         = 7;
	localparam int ORDER_W       = 3;

	localparam logic [DATA_W-1:0]  MISSING_CODE = 32'h8000_0000;
	localparam logic [LAG_W-1:0]   LAG_RST      = 7'd1;
	localparam logic [ORDER_W-1:0] ORDER_RST    = 3'd1;
	localparam logic [DATA_W-1:0]  FILL_RST     = MISSING_CODE;

	typedef struct packed {
		logic vld;
		logic hl;
	} cell_ctl_t;

	// current minus lagged; missing propagates, overflow gives missing
	function automatic logic [DATA_W-1:0] checked_diff(
		input logic [DATA_W-1:0] lagged,
		input logic [DATA_W-1:0] current
	);
		logic signed [DATA_W:0] d;
		logic [DATA_W-1:0] r;
		d = $signed({current[DATA_W-1], current}) - $signed({lagged[DATA_W-1], lagged});
		if (lagged == MISSING_CODE || current == MISSING_CODE) begin
			r = MISSING_CODE;
		end else if (d[DATA_W] != d[DATA_W-1]) begin
			r = MISSING_CODE;
		end else begin
			r = d[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/gld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gld_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/gld_cell.sv
// One difference cell: a history ring for its own input and a checked subtract.
module gld_cell #(
	parameter int MAX_LAG = gld_pkg::MAX_LAG_DEF,
	localparam int PW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       tap,
	input  logic [gld_pkg::DATA_W-1:0] fill_code,
	input  gld_pkg::cell_ctl_t         ctl_in,
	input  logic [PW-1:0]              ptr_in,
	input  logic [gld_pkg::DATA_W-1:0] val_in,
	input  logic [gld_pkg::DATA_W-1:0] res_in,
	output gld_pkg::cell_ctl_t         ctl_out,
	output logic [PW-1:0]              ptr_out,
	output logic [gld_pkg::DATA_W-1:0] val_out,
	output logic [gld_pkg::DATA_W-1:0] res_out
);

	gld_pkg::cell_ctl_t         ctl_s1;
	logic [PW-1:0]              ptr_s1;
	logic [gld_pkg::DATA_W-1:0] val_s1;
	logic [gld_pkg::DATA_W-1:0] res_s1;
	logic [gld_pkg::DATA_W-1:0] hist_rd;
	logic [gld_pkg::DATA_W-1:0] diff;

	// read the lagged word and store the incoming one in the same slot
	gld_ram #(
		.WIDTH (gld_pkg::DATA_W),
		.DEPTH (MAX_LAG)
	) u_hist (
		.clk   (clk),
		.we    (adv && ctl_in.vld),
		.waddr (ptr_in),
		.wdata (val_in),
		.re    (adv),
		.raddr (ptr_in),
		.rdata (hist_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ptr_s1 <= ptr_in;
			val_s1 <= val_in;
			res_s1 <= res_in;
		end
	end

	assign diff    = gld_pkg::checked_diff(hist_rd, val_s1);
	assign val_out = ctl_s1.hl ? diff : fill_code;
	assign res_out = tap ? val_out : res_s1;
	assign ctl_out = ctl_s1;
	assign ptr_out = ptr_s1;

endmodule

FILE: rtl/grouped_lagged_difference.sv
// Top level: run tracking, register port, chain of difference cells and output buffer.
// Takes one sample per clock while sample_stall is low and returns one difference per
// sample, in order. A sample passes through MAX_ORDER difference cells and is then
// loaded into a two-entry output buffer. Every cell holds a MAX_LAG-word history RAM
// that is read and written once per sample, and all cells run on every sample;
// difference_order only picks which cell's output is returned. sample_stall rises only
// when the output buffer is full, that is when difference_stall holds a result at the
// edge at which the next one arrives; the whole chain then holds until the first entry
// is taken. A write to lag_distance starts a new run. Registers: 0x0 lag_distance,
// 0x4 difference_order, 0x8 fill_code; write them only while idle.
module grouped_lagged_difference #(
	parameter int MAX_LAG   = gld_pkg::MAX_LAG_DEF,
	parameter int MAX_ORDER = gld_pkg::MAX_ORDER_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic [gld_pkg::DATA_W-1:0] sample,
	input  logic                       new_run,
	output logic                       difference_valid,
	input  logic                       difference_stall,
	output logic [gld_pkg::DATA_W-1:0] difference
);

	localparam int PW    = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
	localparam int CNT_W = $clog2(MAX_LAG + 1);
	localparam int CW    = (CNT_W > gld_pkg::LAG_W) ? CNT_W : gld_pkg::LAG_W;
	localparam int OW    = $clog2(MAX_ORDER + 1);
	localparam int OCW   = (OW > gld_pkg::ORDER_W) ? OW : gld_pkg::ORDER_W;

	localparam logic [1:0] REG_LAG   = 2'd0;
	localparam logic [1:0] REG_ORDER = 2'd1;
	localparam logic [1:0] REG_FILL  = 2'd2;

	logic [gld_pkg::LAG_W-1:0]   lag_q;
	logic [gld_pkg::ORDER_W-1:0] order_q;
	logic [gld_pkg::DATA_W-1:0]  fill_q;
	logic [CNT_W-1:0]            pos_q;
	logic [PW-1:0]               hptr_q;

	logic                        cfg_wr;
	logic [1:0]                  cfg_idx;
	logic                        adv;
	logic                        accept;
	logic [CW-1:0]               lag_ext;
	logic [CNT_W-1:0]            eff_lag;
	logic [OCW-1:0]              order_ext;
	logic [OCW-1:0]              eff_order;
	logic [CNT_W-1:0]            pos_cur;
	logic [PW-1:0]               hptr_cur;
	logic [PW-1:0]               ptr_cur;
	logic [CNT_W-1:0]            ptr_inc;
	logic [MAX_ORDER-1:0]        tap;

	gld_pkg::cell_ctl_t          ctl_c [MAX_ORDER+1];
	logic [PW-1:0]               ptr_c [MAX_ORDER+1];
	logic [gld_pkg::DATA_W-1:0]  val_c [MAX_ORDER+1];
	logic [gld_pkg::DATA_W-1:0]  res_c [MAX_ORDER+1];

	logic                        out_vld_q;
	logic [gld_pkg::DATA_W-1:0]  out_q;
	logic                        skid_vld_q;
	logic [gld_pkg::DATA_W-1:0]  skid_q;
	logic                        push;
	logic                        pop;

	// register port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_LAG:   prdata = {{(32 - gld_pkg::LAG_W){1'b0}}, lag_q};
			REG_ORDER: prdata = {{(32 - gld_pkg::ORDER_W){1'b0}}, order_q};
			REG_FILL:  prdata = fill_q;
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q   <= gld_pkg::LAG_RST;
			order_q <= gld_pkg::ORDER_RST;
			fill_q  <= gld_pkg::FILL_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LAG:   lag_q   <= pwdata[gld_pkg::LAG_W-1:0];
				REG_ORDER: order_q <= pwdata[gld_pkg::ORDER_W-1:0];
				REG_FILL:  fill_q  <= pwdata;
				default:   ;
			endcase
		end
	end

	// clamp lag and order into their working ranges
	assign lag_ext   = CW'(lag_q);
	assign eff_lag   = (lag_q == '0) ? CNT_W'(1) :
	                   (lag_ext > CW'(MAX_LAG)) ? CNT_W'(MAX_LAG) : CNT_W'(lag_ext);
	assign order_ext = OCW'(order_q);
	assign eff_order = (order_q == '0) ? OCW'(1) :
	                   (order_ext > OCW'(MAX_ORDER)) ? OCW'(MAX_ORDER) : order_ext;

	for (genvar s = 0; s < MAX_ORDER; s++) begin : g_tap
		assign tap[s] = (eff_order == OCW'(s + 1));
	end

	// run tracking
	assign adv          = !skid_vld_q;
	assign sample_stall = skid_vld_q;
	assign accept       = sample_valid && adv;

	assign pos_cur  = new_run ? '0 : pos_q;
	assign hptr_cur = new_run ? '0 : hptr_q;
	assign ptr_cur  = (CNT_W'(hptr_cur) >= eff_lag) ? '0 : hptr_cur;
	assign ptr_inc  = CNT_W'(ptr_cur) + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hptr_q <= '0;
		end else if (cfg_wr && cfg_idx == REG_LAG) begin
			pos_q  <= '0;
			hptr_q <= '0;
		end else if (accept) begin
			hptr_q <= (ptr_inc >= eff_lag) ? '0 : PW'(ptr_inc);
			if (pos_cur < CNT_W'(MAX_LAG)) begin
				pos_q <= pos_cur + CNT_W'(1);
			end else begin
				pos_q <= pos_cur;
			end
		end
	end

	// cell chain
	assign ctl_c[0].vld = sample_valid;
	assign ctl_c[0].hl  = (pos_cur >= eff_lag);
	assign ptr_c[0]     = ptr_cur;
	assign val_c[0]     = sample;
	assign res_c[0]     = '0;

	for (genvar s = 0; s < MAX_ORDER; s++) begin : g_cell
		gld_cell #(
			.MAX_LAG (MAX_LAG)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.tap       (tap[s]),
			.fill_code (fill_q),
			.ctl_in    (ctl_c[s]),
			.ptr_in    (ptr_c[s]),
			.val_in    (val_c[s]),
			.res_in    (res_c[s]),
			.ctl_out   (ctl_c[s+1]),
			.ptr_out   (ptr_c[s+1]),
			.val_out   (val_c[s+1]),
			.res_out   (res_c[s+1])
		);
	end

	// two-entry output buffer; the chain holds while the second entry is full
	assign push = adv && ctl_c[MAX_ORDER].vld;
	assign pop  = out_vld_q && !difference_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop || !out_vld_q) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_vld_q) begin
			out_q <= skid_vld_q ? skid_q : res_c[MAX_ORDER];
		end else if (push) begin
			skid_q <= res_c[MAX_ORDER];
		end
	end

	assign difference_valid = out_vld_q;
	assign difference       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("second output entry held with the first empty");

	a_lag_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && cfg_idx == REG_LAG) |=> (pos_q == '0 && hptr_q == '0))
		else $error("lag write did not restart the run");

	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(hptr_q) < eff_lag)
		else $error("history pointer outside the lag ring");

endmodule

FILE: test/gld_difference_checker.sv
// Register tracking, difference prediction and result compare for the lagged difference block.
package gld_tb_pkg;
	typedef enum logic [1:0] {REG_LAG = 2'd0, REG_ORDER = 2'd1, REG_FILL = 2'd2} reg_index_t;
endpackage

module gld_difference_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	input  logic                       sample_valid,
	input  logic                       sample_stall,
	input  logic [gld_pkg::DATA_W-1:0] sample,
	input  logic                       new_run,
	input  logic                       difference_valid,
	input  logic                       difference_stall,
	input  logic [gld_pkg::DATA_W-1:0] difference,
	output int                         errors,
	output int                         pending,
	output int                         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [gld_pkg::LAG_W-1:0]   cfg_lag;
	logic [gld_pkg::ORDER_W-1:0] cfg_order;
	logic [gld_pkg::DATA_W-1:0]  cfg_fill;
	logic [gld_pkg::DATA_W-1:0]  hist [gld_pkg::MAX_ORDER_DEF][gld_pkg::MAX_LAG_DEF];
	int                          run_pos;
	int                          ring_slot;
	logic [gld_pkg::DATA_W-1:0]  expected_diffs [$];

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns ERROR: %s", $realtime, what);
	endtask

	// current minus lagged; missing propagates, out of range gives missing
	function automatic logic [gld_pkg::DATA_W-1:0] lagged_diff(
		input logic [gld_pkg::DATA_W-1:0] lagged,
		input logic [gld_pkg::DATA_W-1:0] current
	);
		longint a;
		longint b;
		longint d;
		if (lagged == gld_pkg::MISSING_CODE || current == gld_pkg::MISSING_CODE) begin
			return gld_pkg::MISSING_CODE;
		end
		a = $signed(current);
		b = $signed(lagged);
		d = a - b;
		if (d > 2147483647 || d < -2147483647) begin
			return gld_pkg::MISSING_CODE;
		end
		return d[gld_pkg::DATA_W-1:0];
	endfunction

	function automatic logic [gld_pkg::DATA_W-1:0] predict_difference(
		input logic [gld_pkg::DATA_W-1:0] smp,
		input logic                       starts_run
	);
		int lag_eff;
		int order_eff;
		int slot;
		bit have_lagged;
		logic [gld_pkg::DATA_W-1:0] v;
		logic [gld_pkg::DATA_W-1:0] old;
		logic [gld_pkg::DATA_W-1:0] res;
		lag_eff = (cfg_lag == 0) ? 1 :
			((cfg_lag > gld_pkg::MAX_LAG_DEF) ? gld_pkg::MAX_LAG_DEF : int'(cfg_lag));
		order_eff = (cfg_order == 0) ? 1 :
			((cfg_order > gld_pkg::MAX_ORDER_DEF) ? gld_pkg::MAX_ORDER_DEF : int'(cfg_order));
		if (starts_run) begin
			run_pos = 0;
			ring_slot = 0;
		end
		slot = (ring_slot >= lag_eff) ? 0 : ring_slot;
		have_lagged = run_pos >= lag_eff;
		v = smp;
		res = '0;
		// every stage updates its history; the order only selects the tap
		for (int s = 0; s < gld_pkg::MAX_ORDER_DEF; s++) begin
			old = hist[s][slot];
			hist[s][slot] = v;
			v = have_lagged ? lagged_diff(old, v) : cfg_fill;
			if (s + 1 == order_eff) begin
				res = v;
			end
		end
		ring_slot = (slot + 1 >= lag_eff) ? 0 : slot + 1;
		if (run_pos < gld_pkg::MAX_LAG_DEF) begin
			run_pos++;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [gld_pkg::DATA_W-1:0] want;
		if (!arst_n) begin
			cfg_lag = gld_pkg::LAG_RST;
			cfg_order = gld_pkg::ORDER_RST;
			cfg_fill = gld_pkg::FILL_RST;
			run_pos = 0;
			ring_slot = 0;
			for (int s = 0; s < gld_pkg::MAX_ORDER_DEF; s++) begin
				for (int k = 0; k < gld_pkg::MAX_LAG_DEF; k++) begin
					hist[s][k] = '0;
				end
			end
			expected_diffs.delete();
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					gld_tb_pkg::REG_LAG: begin
						// a new lag restarts the run
						cfg_lag = pwdata[gld_pkg::LAG_W-1:0];
						run_pos = 0;
						ring_slot = 0;
					end
					gld_tb_pkg::REG_ORDER: begin
						cfg_order = pwdata[gld_pkg::ORDER_W-1:0];
					end
					gld_tb_pkg::REG_FILL: begin
						cfg_fill = pwdata[gld_pkg::DATA_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (difference_valid && !difference_stall) begin
				if (expected_diffs.size() == 0) begin
					report_mismatch($sformatf("difference %h with no request pending",
						difference));
				end else begin
					want = expected_diffs.pop_front();
					if (difference !== want) begin
						report_mismatch($sformatf("difference %h, expected %h (result %0d)",
							difference, want, checked));
					end
					checked++;
				end
			end
			if (sample_valid && !sample_stall) begin
				expected_diffs.push_back(predict_difference(sample, new_run));
			end
			pending <= expected_diffs.size();
		end
	end

endmodule

FILE: test/grouped_lagged_difference_tb.sv
// Top of the lagged difference testbench: clock, reset, stimulus, idling and verdict.
module grouped_lagged_difference_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 850;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [3:0]                 paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic [gld_pkg::DATA_W-1:0] sample = '0;
	logic                       new_run = 1'b0;
	logic                       difference_valid;
	logic                       difference_stall = 1'b0;
	logic [gld_pkg::DATA_W-1:0] difference;

	logic calm = 1'b0;
	int   stall_left = 0;
	int   errors;
	int   pending;
	int   checked;
	int   cycle_count = 0;
	int   sent_total = 0;
	int   random_sent = 0;
	int   phase_count = 0;
	int   lag_now = 1;
	int   run_left = 0;

	always #6ns clk = ~clk;

	grouped_lagged_difference dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.sample           (sample),
		.new_run          (new_run),
		.difference_valid (difference_valid),
		.difference_stall (difference_stall),
		.difference       (difference)
	);

	gld_difference_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.pready           (pready),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.sample           (sample),
		.new_run          (new_run),
		.difference_valid (difference_valid),
		.difference_stall (difference_stall),
		.difference       (difference),
		.errors           (errors),
		.pending          (pending),
		.checked          (checked)
	);

	// receiver stalls in bursts of random length
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			stall_left <= 0;
			difference_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			difference_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			difference_stall <= 1'b1;
		end else begin
			difference_stall <= 1'b0;
		end
	end

	task automatic send_item(input logic [gld_pkg::DATA_W-1:0] v, input logic starts_run);
		if (!calm && $urandom_range(0, 7) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		sample <= v;
		new_run <= starts_run;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		sent_total++;
	endtask

	// hold off until every request has its result, then let the pipe settle
	task automatic drain_pipeline();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * gld_pkg::MAX_ORDER_DEF) @(posedge clk);
	endtask

	task automatic apb_write(input gld_tb_pkg::reg_index_t idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 4'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic write_settings(
		input bit do_lag,   input int lag,
		input bit do_order, input int order,
		input bit do_fill,  input logic [31:0] fill
	);
		// upper bits beyond the register width carry noise
		if (do_lag) begin
			apb_write(gld_tb_pkg::REG_LAG, ($urandom() & 32'hFFFF_FF80) | 32'(lag));
			lag_now = (lag == 0) ? 1 :
				((lag > gld_pkg::MAX_LAG_DEF) ? gld_pkg::MAX_LAG_DEF : lag);
		end
		if (do_order) begin
			apb_write(gld_tb_pkg::REG_ORDER, ($urandom() & 32'hFFFF_FFF8) | 32'(order));
		end
		if (do_fill) begin
			apb_write(gld_tb_pkg::REG_FILL, fill);
		end
		if (do_lag || do_order || do_fill) begin
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [gld_pkg::DATA_W-1:0] random_sample();
		logic [gld_pkg::DATA_W-1:0] r;
		case ($urandom_range(0, 19))
			0: r = gld_pkg::MISSING_CODE;
			1: r = 32'h7FFF_FFFF;
			2: r = 32'h8000_0001;
			3, 4: r = $urandom();
			default: r = int'($urandom_range(0, 400)) - 200;
		endcase
		return r;
	endfunction

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int          lag_set [4];
		int          order_set [4];
		logic [31:0] fill_set [4];
		int          lag_pick;
		int          order_pick;
		logic [31:0] fill_pick;
		bit          w_lag;
		bit          w_order;
		bit          w_fill;
		int          phase_len;
		logic        nr;

		lag_set = '{64, 2, 5, 127};
		order_set = '{4, 2, 3, 5};
		fill_set = '{32'h7FFF_FFFF, 32'hFFFF_FFF9, gld_pkg::MISSING_CODE, 32'h0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; the first sample opens a run without new_run
		send_item(32'd0, 1'b0);
		send_item(32'd5, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0001, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(gld_pkg::MISSING_CODE, 1'b0);
		send_item(32'd7, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'h8000_0001, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'd42, 1'b1);
		drain_pipeline();

		// order above range, lag zero, fill at the positive extreme fed to later stages
		write_settings(1'b1, 0, 1'b1, 7, 1'b1, 32'h7FFF_FFFF);
		send_item(32'd10, 1'b1);
		send_item(32'd20, 1'b0);
		send_item(32'd25, 1'b0);
		send_item(32'd25, 1'b0);
		send_item(32'hFFFF_FFFD, 1'b0);
		send_item(32'd4, 1'b1);
		send_item(32'd8, 1'b0);
		drain_pipeline();

		// lag above range, order zero, zero fill
		write_settings(1'b1, 127, 1'b1, 0, 1'b1, 32'h0);
		send_item(32'd3, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'd9, 1'b1);

		while (random_sent < RANDOM_ITEMS) begin
			drain_pipeline();
			calm <= (random_sent > RANDOM_ITEMS * 4 / 5) || ($urandom_range(0, 3) == 0);
			if (phase_count < 4) begin
				write_settings(1'b1, lag_set[phase_count], 1'b1, order_set[phase_count],
					1'b1, fill_set[phase_count]);
			end else begin
				w_lag = ($urandom_range(0, 2) == 0);
				w_order = ($urandom_range(0, 1) == 0);
				w_fill = ($urandom_range(0, 1) == 0);
				lag_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
					: $urandom_range(1, 6);
				order_pick = $urandom_range(0, 7);
				case ($urandom_range(0, 4))
					0: fill_pick = gld_pkg::MISSING_CODE;
					1: fill_pick = 32'h0;
					2: fill_pick = int'($urandom_range(0, 60)) - 30;
					3: fill_pick = 32'h7FFF_FFFF;
					default: fill_pick = $urandom();
				endcase
				write_settings(w_lag, lag_pick, w_order, order_pick, w_fill, fill_pick);
			end
			phase_len = 30 + 2 * lag_now + $urandom_range(0, 20);
			if (phase_len > RANDOM_ITEMS - random_sent) begin
				phase_len = RANDOM_ITEMS - random_sent;
			end
			// sometimes carry the current run across the setting change
			if ($urandom_range(0, 2) != 0) begin
				run_left = 0;
			end
			repeat (phase_len) begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 2 * lag_now + 6);
					nr = 1'b1;
				end else begin
					nr = ($urandom_range(0, 29) == 0);
				end
				run_left--;
				send_item(random_sample(), nr);
				random_sent++;
			end
			phase_count++;
		end

		drain_pipeline();
		repeat (20) @(posedge clk);
		$display("Sent %0d samples (%0d directed) over %0d setting phases; %0d differences checked.",
			sent_total, sent_total - random_sent, phase_count + 3, checked);
		$display("Lags and orders in and out of range, fill codes at the extremes and missing, "
			, "runs carried across setting changes, idling on both channels.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/gld_pkg.sv
rtl/gld_ram.sv
rtl/gld_cell.sv
rtl/grouped_lagged_difference.sv
test/gld_difference_checker.sv
test/grouped_lagged_difference_tb.sv
